/* src/float32_to_narrow_float_encoder_assert.svh */
// Assertion macros for the float32 encoder.
`ifndef FLOAT32_TO_NARROW_FLOAT_ENCODER_ASSERT_SVH
`define FLOAT32_TO_NARROW_FLOAT_ENCODER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define F2N_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define F2N_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/f2n_pkg.sv */
`default_nettype none
package f2n_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned FmtW = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [1:0] {
    FmtBfloat16 = 2'd0,
    FmtHalf     = 2'd1,
    FmtSingle   = 2'd2,
    FmtSpare    = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNonfinite = 2'd1,
    StOverflow  = 2'd2,
    StSpare     = 2'd3
  } status_e;
endpackage
`default_nettype wire

/* src/float32_to_narrow_float_encoder.sv */
// float32_to_narrow_float_encoder
// Each accepted input transaction is converted and its result registered in the output register.
// Throughput: one transaction per cycle while the output is not stalled; the single conversion stage sets this.
// The output register accepts a new item in the same cycle its result is taken.
// Reset (rst_ni low, async): output valid cleared, target_format back to bfloat16.
`default_nettype none
module float32_to_narrow_float_encoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [f2n_pkg::FmtW-1:0]      cfg_wdata_i,  // target_format
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [f2n_pkg::ValueW-1:0]    s_axis_tdata,  // [31:0] value_bits
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata   // [31:0] encoded, [33:32] status
);
  import f2n_pkg::*;

  logic [FmtW-1:0]    fmt_q;
  logic               vld_q;
  logic [31:0]        enc_q, enc_d;
  logic [StatusW-1:0] st_q, st_d;

  // stage is free when empty or being drained
  assign s_axis_tready = !vld_q || m_axis_tready;
  wire in_fire = s_axis_tvalid && s_axis_tready;

  logic [31:0] bits;
  logic [7:0]  expo;
  logic [22:0] frac;
  // bfloat16
  logic [16:0] bf_r;
  logic [15:0] bf_low;
  logic        bf_up;
  // binary16 normal path
  logic [9:0]  h_kept;
  logic [12:0] h_rest;
  logic        h_up;
  logic [10:0] h_r;
  logic [5:0]  h_exp;
  // binary16 subnormal path: shift 14..24 of 24-bit significand
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [23:0] s_kept, s_rest, s_half, s_mask;
  logic        s_up;
  logic [10:0] s_r;

  always_comb begin
    bits = s_axis_tdata;
    if (bits[30:0] == 31'd0) bits = '0;  // negative zero to positive zero
    expo = bits[30:23];
    frac = bits[22:0];
    st_d = StOk;
    enc_d = '0;

    bf_low = bits[15:0];
    bf_up  = (bf_low > 16'h8000) || (bf_low == 16'h8000 && bits[16]);
    bf_r   = {1'b0, bits[31:16]} + {16'd0, bf_up};

    h_kept = frac[22:13];
    h_rest = frac[12:0];
    h_up   = (h_rest > 13'h1000) || (h_rest == 13'h1000 && h_kept[0]);
    h_r    = {1'b0, h_kept} + {10'd0, h_up};
    // power+15 = expo-112, plus carry
    h_exp  = 6'(expo - 8'd112) + {5'd0, h_r[10]};

    sig    = {1'b1, frac};
    // power in [-25,-15]: shift = -power-1 = 126-expo
    sh     = 5'(8'd126 - expo);
    s_kept = sig >> sh;
    s_mask = (24'd1 << sh) - 24'd1;
    s_rest = sig & s_mask;
    s_half = 24'd1 << (sh - 5'd1);
    s_up   = (s_rest > s_half) || (s_rest == s_half && s_kept[0]);
    s_r    = s_kept[10:0] + {10'd0, s_up};

    if (s_axis_tdata[30:23] == 8'hff) begin
      st_d = StNonfinite;
    end else begin
      case (fmt_q)
        FmtBfloat16: begin
          if (bf_r[14:7] == 8'hff) st_d = StOverflow;
          else if (bf_r[14:0] != 15'd0) enc_d = {16'd0, bf_r[15:0]};
        end
        FmtHalf: begin
          if (expo == 8'd0 || expo < 8'd102) begin
            enc_d = '0;
          end else if (expo > 8'd142) begin
            st_d = StOverflow;
          end else if (expo < 8'd113) begin
            if (s_r != 11'd0) enc_d = {16'd0, bits[31], 4'd0, s_r};
          end else if (h_exp >= 6'd31) begin
            st_d = StOverflow;
          end else begin
            enc_d = {16'd0, bits[31], h_exp[4:0], h_r[9:0]};
          end
        end
        default: enc_d = bits;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtW'(FmtBfloat16);
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (s_axis_tready) vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      enc_q <= enc_d;
      st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {6'd0, st_q, enc_q};

`include "float32_to_narrow_float_encoder_assert.svh"
  `F2N_ASSERT(a_err_zero, clk_i, rst_ni, !vld_q || st_q == StOk || enc_q == 32'd0, "error with data")
  `F2N_ASSERT(a_st_range, clk_i, rst_ni, !vld_q || st_q != StSpare, "bad status")
  `F2N_ASSERT_NEXT(a_fire_vld, clk_i, rst_ni, in_fire, vld_q, "lost item")
  `F2N_ASSERT_NEXT(a_hold, clk_i, rst_ni, vld_q && !m_axis_tready, vld_q && $stable(enc_q), "dropped result")
endmodule
`default_nettype wire
